// File: sv/dsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsi_pkg
// types and constants shared by the decimal string parser and its channels
// ----------------------------------------------------------------------------
package dsi_pkg;

  localparam int CHAR_W     = 8;
  localparam int VALUE_W    = 64;
  localparam int NARROW_W   = 32;
  localparam int DIGIT_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STRICT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd1;

  localparam logic [1:0] WM_S32 = 2'd0;
  localparam logic [1:0] WM_S64 = 2'd1;
  localparam logic [1:0] WM_U32 = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [DIGIT_W-1:0] LAST_DIGIT_AT_LIMIT = 4'd8;

  // most negative value divided by ten, truncated toward zero
  localparam logic [VALUE_W-1:0] LIM_S32 = 64'hFFFF_FFFF_F333_3334;
  localparam logic [VALUE_W-1:0] LIM_S64 = 64'hF333_3333_3333_3334;
  localparam logic [VALUE_W-1:0] MIN_S32 = 64'hFFFF_FFFF_8000_0000;
  localparam logic [VALUE_W-1:0] MIN_S64 = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    PH_SKIP    = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

endpackage

// File: sv/dsi_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsi_in_if
// character channel: one string character per transaction
// ----------------------------------------------------------------------------
interface dsi_in_if;
  import dsi_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

// File: sv/dsi_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsi_out_if
// result channel: parsed value and success flag per transaction
// ----------------------------------------------------------------------------
interface dsi_out_if;
  import dsi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] parsed_value;
  logic                      parse_ok;

  modport source (output valid, output parsed_value, output parse_ok, input ready);
  modport sink   (input valid, input parsed_value, input parse_ok, output ready);
endinterface

// File: sv/decimal_string_to_integer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_string_to_integer
// streaming decimal string parser with strict and wrapping modes
// throughput: one character per cycle, unless end of string waits for the
//   output, set by the combinational accumulator step (times ten, subtract
//   digit, final negate) on the registered input; result in out_value_r
// reset: synchronous active-low, clears parser state, config registers and valids
// ----------------------------------------------------------------------------
module decimal_string_to_integer (
  input  logic                              clk,
  input  logic                              rst_n,
  dsi_in_if.sink                            in_ch,
  dsi_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [dsi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import dsi_pkg::*;

  logic               strict_r;
  logic [1:0]         wmode_r;

  logic               s1_valid_r;
  logic [CHAR_W-1:0]  s1_char_r;
  logic               s1_eos_r;

  phase_t             phase_r, phase_nxt;
  logic               neg_r, neg_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               fail_r, fail_nxt;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_ok_r, out_ok_nxt;

  logic               narrow;
  logic               out_free;
  logic               s1_adv;
  logic               step_en;
  logic               take;
  logic               is_digit;
  logic [DIGIT_W-1:0] digit;
  logic [VALUE_W-1:0] lim;
  logic [VALUE_W-1:0] min_val;
  logic               over_lim;
  logic [VALUE_W-1:0] acc_raw;
  logic [VALUE_W-1:0] acc_step;
  logic [VALUE_W-1:0] acc_negated;
  logic [VALUE_W-1:0] val_pos;
  logic [VALUE_W-1:0] val_sel;

  assign narrow   = (wmode_r == WM_S32);
  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = !s1_eos_r || out_free;
  assign step_en  = s1_valid_r && s1_adv;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // digit step
  assign is_digit = (s1_char_r >= CH_ZERO) && (s1_char_r <= CH_NINE);
  assign digit    = DIGIT_W'(s1_char_r - CH_ZERO);
  assign lim      = narrow ? LIM_S32 : LIM_S64;
  assign min_val  = narrow ? MIN_S32 : MIN_S64;
  assign over_lim = ($signed(acc_r) < $signed(lim)) ||
                    ((acc_r == lim) && (digit > LAST_DIGIT_AT_LIMIT));
  assign acc_raw  = (acc_r << 3) + (acc_r << 1) - VALUE_W'(digit);
  assign acc_step = narrow ? {{(VALUE_W-NARROW_W){acc_raw[NARROW_W-1]}},
                              acc_raw[NARROW_W-1:0]} : acc_raw;

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    fail_nxt  = fail_r;
    take      = 1'b0;
    unique case (phase_r)
      PH_SKIP: begin
        if (s1_char_r != CH_SPACE) begin
          phase_nxt = PH_DIGITS;
          if ((s1_char_r == CH_MINUS) || (s1_char_r == CH_PLUS)) begin
            neg_nxt = (s1_char_r == CH_MINUS);
          end else begin
            take = 1'b1;
          end
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      PH_STOPPED: begin
        take = 1'b0;
      end
      default: begin
        take = 1'b0;
      end
    endcase
    if (take) begin
      if (s1_char_r == CH_NUL) begin
        phase_nxt = PH_STOPPED;
      end else if (!is_digit) begin
        if (strict_r) begin
          fail_nxt = 1'b1;
        end
        phase_nxt = PH_STOPPED;
      end else if (strict_r && over_lim) begin
        fail_nxt  = 1'b1;
        phase_nxt = PH_STOPPED;
      end else begin
        acc_nxt = acc_step;
      end
    end
  end

  // final value and checks
  assign acc_negated = '0 - acc_nxt;
  assign val_pos = narrow ? {{(VALUE_W-NARROW_W){acc_negated[NARROW_W-1]}},
                             acc_negated[NARROW_W-1:0]} : acc_negated;
  assign val_sel = neg_nxt ? acc_nxt : val_pos;

  always_comb begin
    out_ok_nxt = !fail_nxt;
    if (strict_r && !neg_nxt && (acc_nxt == min_val)) begin
      out_ok_nxt = 1'b0;
    end
    if (wmode_r[1] && (val_sel[VALUE_W-1:NARROW_W] != '0)) begin
      out_ok_nxt = 1'b0;
    end
    out_value_nxt = out_ok_nxt ? val_sel : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
      wmode_r  <= WM_S32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STRICT: strict_r <= cfg_wdata[0];
        CFG_WIDTH:  wmode_r  <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.char_code;
      s1_eos_r  <= in_ch.end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      fail_r  <= 1'b0;
    end else if (step_en) begin
      if (s1_eos_r) begin
        phase_r <= PH_SKIP;
        neg_r   <= 1'b0;
        acc_r   <= '0;
        fail_r  <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
        fail_r  <= fail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && s1_eos_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && s1_eos_r) begin
      out_value_r <= out_value_nxt;
      out_ok_r    <= out_ok_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.parsed_value = $signed(out_value_r);
  assign out_ch.parse_ok     = out_ok_r;

endmodule
